@@ sv/smpte_timecode_stepper_top_macros.svh @@
// Assertion macros used by the timecode stepper checker.
`ifndef SMPTE_TIMECODE_STEPPER_TOP_MACROS_SVH
`define SMPTE_TIMECODE_STEPPER_TOP_MACROS_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define SMPTE_TS_ASSERT_CLK(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the default clk_i / rst_ni pair.
`define SMPTE_TS_ASSERT(name, prop, msg) \
  `SMPTE_TS_ASSERT_CLK(name, clk_i, rst_ni, prop, msg)

`endif

@@ sv/smpte_ts_pkg.sv @@
// Package: types, codes, constants and helper functions of the timecode stepper.
`default_nettype none

package smpte_ts_pkg;

  localparam int unsigned HOUR_WIDTH_DEF = 8;
  localparam int unsigned APB_ADDR_W     = 4;
  localparam int unsigned APB_DATA_W     = 32;

  localparam logic [5:0] SEC_TOP         = 6'd59;
  localparam logic [5:0] MIN_TOP         = 6'd59;
  localparam logic [5:0] DROP_FIRST_FRM  = 6'd2;

  localparam logic [1:0] RATE_MODE_RST   = 2'd2;
  localparam logic       DROP_FRAME_RST  = 1'b0;
  localparam logic [7:0] SUBFRAMES_RST   = 8'd80;

  typedef enum logic [1:0] {
    RATE_24 = 2'd0,
    RATE_25 = 2'd1,
    RATE_30 = 2'd2,
    RATE_60 = 2'd3
  } rate_e;

  typedef enum logic [1:0] {
    REG_RATE_MODE  = 2'd0,
    REG_DROP_FRAME = 2'd1,
    REG_SUBFRAMES  = 2'd2
  } reg_e;

  typedef enum logic [2:0] {
    WRAP_NONE    = 3'd0,
    WRAP_FRAMES  = 3'd1,
    WRAP_SECONDS = 3'd2,
    WRAP_MINUTES = 3'd3,
    WRAP_HOURS   = 3'd4
  } wrap_e;

  typedef enum logic [3:0] {
    OP_LOAD        = 4'd0,
    OP_INC_FRAME   = 4'd1,
    OP_DEC_FRAME   = 4'd2,
    OP_INC_SUB     = 4'd3,
    OP_DEC_SUB     = 4'd4,
    OP_NEXT_SEC    = 4'd5,
    OP_NEXT_MIN    = 4'd6,
    OP_NEXT_HOUR   = 4'd7,
    OP_FLOOR_SEC   = 4'd8,
    OP_FLOOR_MIN   = 4'd9,
    OP_FLOOR_HOUR  = 4'd10,
    OP_FLOOR_FRAME = 4'd11
  } op_e;

  typedef struct packed {
    rate_e      rate_mode;
    logic       drop_frame;
    logic [7:0] frame_subs;
  } cfg_t;

  typedef struct packed {
    logic [3:0] op;
    logic       load_negative;
    logic [7:0] load_hours;
    logic [5:0] load_minutes;
    logic [5:0] load_seconds;
    logic [5:0] load_frames;
    logic [7:0] load_subframes;
  } item_t;

  typedef struct packed {
    logic [2:0] wrap_level;
    logic       is_negative;
    logic [7:0] hours_out;
    logic [5:0] minutes_out;
    logic [5:0] seconds_out;
    logic [5:0] frames_out;
    logic [7:0] subframes_out;
  } res_t;

  // Last frame number of a second.
  function automatic logic [5:0] top_frame(rate_e rate);
    logic [5:0] t;
    case (rate)
      RATE_24: t = 6'd23;
      RATE_25: t = 6'd24;
      RATE_30: t = 6'd29;
      RATE_60: t = 6'd59;
      default: t = 6'd29;
    endcase
    return t;
  endfunction

  // True for a multiple of ten (range 0..64 is all that occurs).
  function automatic logic is_tens(logic [6:0] v);
    return v inside {7'd0, 7'd10, 7'd20, 7'd30, 7'd40, 7'd50, 7'd60};
  endfunction

endpackage

`default_nettype wire

@@ sv/smpte_ts_in_if.sv @@
// Command channel interface: valid/ready plus one command's fields.
`default_nettype none

interface smpte_ts_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] op;
  logic       load_negative;
  logic [7:0] load_hours;
  logic [5:0] load_minutes;
  logic [5:0] load_seconds;
  logic [5:0] load_frames;
  logic [7:0] load_subframes;

  modport source (
    output valid, op, load_negative, load_hours, load_minutes, load_seconds,
           load_frames, load_subframes,
    input  ready
  );

  modport sink (
    input  valid, op, load_negative, load_hours, load_minutes, load_seconds,
           load_frames, load_subframes,
    output ready
  );
endinterface

`default_nettype wire

@@ sv/smpte_ts_out_if.sv @@
// Result channel interface: valid/ready plus one result's fields.
`default_nettype none

interface smpte_ts_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] wrap_level;
  logic       is_negative;
  logic [7:0] hours_out;
  logic [5:0] minutes_out;
  logic [5:0] seconds_out;
  logic [5:0] frames_out;
  logic [7:0] subframes_out;

  modport source (
    output valid, wrap_level, is_negative, hours_out, minutes_out, seconds_out,
           frames_out, subframes_out,
    input  ready
  );

  modport sink (
    input  valid, wrap_level, is_negative, hours_out, minutes_out, seconds_out,
           frames_out, subframes_out,
    output ready
  );
endinterface

`default_nettype wire

@@ sv/smpte_ts_cfg.sv @@
// APB configuration registers: frame rate, drop-frame enable, subframes per frame.
`default_nettype none

module smpte_ts_cfg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [smpte_ts_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [smpte_ts_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [smpte_ts_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                 pready,
  output smpte_ts_pkg::cfg_t                   cfg_o
);

  smpte_ts_pkg::rate_e rate_q;
  logic                drop_q;
  logic [7:0]          spf_q;
  logic                wr_en;
  smpte_ts_pkg::reg_e  sel;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign sel    = smpte_ts_pkg::reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= smpte_ts_pkg::rate_e'(smpte_ts_pkg::RATE_MODE_RST);
      drop_q <= smpte_ts_pkg::DROP_FRAME_RST;
      spf_q  <= smpte_ts_pkg::SUBFRAMES_RST;
    end else if (wr_en) begin
      case (sel)
        smpte_ts_pkg::REG_RATE_MODE:  rate_q <= smpte_ts_pkg::rate_e'(pwdata[1:0]);
        smpte_ts_pkg::REG_DROP_FRAME: drop_q <= pwdata[0];
        smpte_ts_pkg::REG_SUBFRAMES:  spf_q  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (sel)
      smpte_ts_pkg::REG_RATE_MODE:  prdata[1:0] = rate_q;
      smpte_ts_pkg::REG_DROP_FRAME: prdata[0]   = drop_q;
      smpte_ts_pkg::REG_SUBFRAMES:  prdata[7:0] = spf_q;
      default: ;
    endcase
  end

  assign cfg_o.rate_mode  = rate_q;
  assign cfg_o.drop_frame = drop_q;
  assign cfg_o.frame_subs = spf_q;

endmodule

`default_nettype wire

@@ sv/smpte_ts_core.sv @@
// Timecode state register and the combinational next-timecode logic for one command.
`default_nettype none

module smpte_ts_core #(
  parameter int unsigned HOUR_WIDTH = smpte_ts_pkg::HOUR_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  smpte_ts_pkg::cfg_t  cfg_i,
  input  logic                adv_i,
  input  smpte_ts_pkg::item_t item_i,
  output smpte_ts_pkg::res_t  res_o
);

  typedef struct packed {
    smpte_ts_pkg::wrap_e   wrap;
    logic                  neg;
    logic [HOUR_WIDTH-1:0] hr;
    logic [5:0]            mn;
    logic [5:0]            sc;
    logic [5:0]            fr;
    logic [7:0]            sb;
  } tc_t;

  logic                  neg_q;
  logic [HOUR_WIDTH-1:0] hr_q;
  logic [5:0]            mn_q;
  logic [5:0]            sc_q;
  logic [5:0]            fr_q;
  logic [7:0]            sb_q;
  tc_t                   cur;
  tc_t                   nxt;

  function automatic logic f_drop(smpte_ts_pkg::cfg_t c);
    return c.drop_frame && (c.rate_mode == smpte_ts_pkg::RATE_30);
  endfunction

  function automatic logic f_around(tc_t s);
    return (s.fr == '0) && (s.sc == '0) && (s.mn == '0) && (s.hr == '0);
  endfunction

  function automatic logic f_zero(tc_t s);
    return f_around(s) && (s.sb == '0);
  endfunction

  function automatic tc_t f_clear(tc_t s);
    tc_t r;
    r = s;
    if (f_zero(r)) r.neg = 1'b0;
    return r;
  endfunction

  // Magnitude up one frame.
  function automatic tc_t f_mag_up(tc_t s, smpte_ts_pkg::cfg_t c);
    tc_t        r;
    logic [5:0] top;
    r   = s;
    top = smpte_ts_pkg::top_frame(c.rate_mode);
    if (r.fr >= top) begin
      if (f_drop(c) && !smpte_ts_pkg::is_tens({1'b0, r.mn} + 7'd1) &&
          (r.sc == smpte_ts_pkg::SEC_TOP)) begin
        r.fr = smpte_ts_pkg::DROP_FIRST_FRM;
      end else begin
        r.fr = '0;
      end
      if (r.sc >= smpte_ts_pkg::SEC_TOP) begin
        r.sc = '0;
        if (r.mn >= smpte_ts_pkg::MIN_TOP) begin
          r.mn   = '0;
          r.hr   = r.hr + HOUR_WIDTH'(1);
          r.wrap = smpte_ts_pkg::WRAP_HOURS;
        end else begin
          r.mn   = r.mn + 6'd1;
          r.wrap = smpte_ts_pkg::WRAP_MINUTES;
        end
      end else begin
        r.sc   = r.sc + 6'd1;
        r.wrap = smpte_ts_pkg::WRAP_SECONDS;
      end
    end else begin
      r.fr   = r.fr + 6'd1;
      r.wrap = smpte_ts_pkg::WRAP_NONE;
    end
    return r;
  endfunction

  // Magnitude down one frame; skipped drop frames borrow early.
  function automatic tc_t f_mag_down(tc_t s, smpte_ts_pkg::cfg_t c);
    tc_t  r;
    logic carry;
    r = s;
    if (f_drop(c) && !smpte_ts_pkg::is_tens({1'b0, r.mn}) && (r.sc == '0)) begin
      carry = (r.fr <= smpte_ts_pkg::DROP_FIRST_FRM);
    end else begin
      carry = (r.fr == '0);
    end
    if (carry) begin
      r.fr = smpte_ts_pkg::top_frame(c.rate_mode);
      if (r.sc == '0) begin
        r.sc = smpte_ts_pkg::SEC_TOP;
        if (r.mn == '0) begin
          r.mn   = smpte_ts_pkg::MIN_TOP;
          r.hr   = r.hr - HOUR_WIDTH'(1);
          r.wrap = smpte_ts_pkg::WRAP_HOURS;
        end else begin
          r.mn   = r.mn - 6'd1;
          r.wrap = smpte_ts_pkg::WRAP_MINUTES;
        end
      end else begin
        r.sc   = r.sc - 6'd1;
        r.wrap = smpte_ts_pkg::WRAP_SECONDS;
      end
    end else begin
      r.fr   = r.fr - 6'd1;
      r      = f_clear(r);
      r.wrap = smpte_ts_pkg::WRAP_NONE;
    end
    return r;
  endfunction

  function automatic tc_t f_frame_up(tc_t s, smpte_ts_pkg::cfg_t c);
    tc_t r;
    r = s;
    if (!r.neg) begin
      r = f_mag_up(r, c);
    end else if (f_around(r) && (r.sb != '0)) begin
      // Fractional negative frame crosses zero.
      r.sb   = c.frame_subs - r.sb;
      r.neg  = 1'b0;
      r.wrap = smpte_ts_pkg::WRAP_SECONDS;
    end else begin
      r     = f_mag_down(r, c);
      r.neg = !f_zero(r);
    end
    return r;
  endfunction

  function automatic tc_t f_frame_down(tc_t s, smpte_ts_pkg::cfg_t c);
    tc_t r;
    r = s;
    if (r.neg || f_zero(r)) begin
      r     = f_mag_up(r, c);
      r.neg = 1'b1;
    end else if (f_around(r) && (r.sb != '0)) begin
      r.sb   = c.frame_subs - r.sb;
      r.neg  = 1'b1;
      r.wrap = smpte_ts_pkg::WRAP_SECONDS;
    end else begin
      r = f_mag_down(r, c);
      r = f_clear(r);
    end
    return r;
  endfunction

  function automatic tc_t f_mag_sub_up(tc_t s, smpte_ts_pkg::cfg_t c);
    tc_t r;
    r = s;
    if (({1'b0, r.sb} + 9'd1) >= {1'b0, c.frame_subs}) begin
      r.sb = '0;
      r    = f_mag_up(r, c);
      r.wrap = smpte_ts_pkg::WRAP_FRAMES;
    end else begin
      r.sb   = r.sb + 8'd1;
      r.wrap = smpte_ts_pkg::WRAP_NONE;
    end
    return r;
  endfunction

  function automatic tc_t f_mag_sub_down(tc_t s, smpte_ts_pkg::cfg_t c);
    tc_t r;
    r = s;
    if (r.sb == '0) begin
      if (f_zero(r)) begin
        r.neg = 1'b1;
        r.sb  = 8'd1;
      end else begin
        r    = f_mag_down(r, c);
        r.sb = c.frame_subs - 8'd1;
      end
      r.wrap = smpte_ts_pkg::WRAP_FRAMES;
    end else begin
      r.sb   = r.sb - 8'd1;
      r.wrap = smpte_ts_pkg::WRAP_NONE;
    end
    return r;
  endfunction

  function automatic tc_t f_sub_up(tc_t s, smpte_ts_pkg::cfg_t c);
    tc_t r;
    r = s;
    if (!r.neg) begin
      r = f_mag_sub_up(r, c);
    end else begin
      r.neg = 1'b0;
      r     = f_mag_sub_down(r, c);
      r.neg = !f_zero(r);
    end
    return r;
  endfunction

  function automatic tc_t f_sub_down(tc_t s, smpte_ts_pkg::cfg_t c);
    tc_t r;
    r = s;
    if (r.neg) begin
      r.neg = 1'b0;
      r     = f_mag_sub_up(r, c);
      r.neg = 1'b1;
    end else begin
      r = f_mag_sub_down(r, c);
    end
    return r;
  endfunction

  function automatic tc_t f_floor_frame(tc_t s);
    tc_t r;
    r    = s;
    r.sb = '0;
    return f_clear(r);
  endfunction

  function automatic tc_t f_floor_sec(tc_t s, smpte_ts_pkg::cfg_t c);
    tc_t r;
    r = f_floor_frame(s);
    if (f_drop(c) && !smpte_ts_pkg::is_tens({1'b0, r.mn}) && (r.sc == '0)) begin
      r.fr = smpte_ts_pkg::DROP_FIRST_FRM;
    end else begin
      r.fr = '0;
    end
    return f_clear(r);
  endfunction

  function automatic tc_t f_floor_min(tc_t s, smpte_ts_pkg::cfg_t c);
    tc_t r;
    r    = s;
    r.sc = '0;
    return f_floor_sec(r, c);
  endfunction

  function automatic tc_t f_floor_hour(tc_t s);
    tc_t r;
    r    = s;
    r.mn = '0;
    r.sc = '0;
    r.fr = '0;
    r.sb = '0;
    return f_clear(r);
  endfunction

  function automatic tc_t f_next_sec(tc_t s, smpte_ts_pkg::cfg_t c);
    tc_t r;
    r = f_floor_frame(s);
    if (r.neg) begin
      r = f_frame_up(r, c);
      r = f_floor_sec(r, c);
    end else begin
      r.fr = smpte_ts_pkg::top_frame(c.rate_mode);
      r    = f_mag_up(r, c);
    end
    return r;
  endfunction

  function automatic tc_t f_next_min(tc_t s, smpte_ts_pkg::cfg_t c);
    tc_t r;
    r = f_floor_frame(s);
    if (r.neg) begin
      r = f_next_sec(r, c);
      r = f_floor_min(r, c);
    end else begin
      r.sc = smpte_ts_pkg::SEC_TOP;
      r    = f_next_sec(r, c);
    end
    return r;
  endfunction

  function automatic tc_t f_next_hour(tc_t s, smpte_ts_pkg::cfg_t c);
    tc_t r;
    r = f_floor_frame(s);
    if (r.neg) begin
      r = f_next_min(r, c);
      r = f_floor_hour(r);
    end else begin
      r.mn = smpte_ts_pkg::MIN_TOP;
      r    = f_next_min(r, c);
    end
    return r;
  endfunction

  always_comb begin
    cur.wrap = smpte_ts_pkg::WRAP_NONE;
    cur.neg  = neg_q;
    cur.hr   = hr_q;
    cur.mn   = mn_q;
    cur.sc   = sc_q;
    cur.fr   = fr_q;
    cur.sb   = sb_q;
  end

  always_comb begin
    nxt = cur;
    case (smpte_ts_pkg::op_e'(item_i.op))
      smpte_ts_pkg::OP_LOAD: begin
        nxt.neg = item_i.load_negative;
        nxt.hr  = HOUR_WIDTH'(item_i.load_hours);
        nxt.mn  = item_i.load_minutes;
        nxt.sc  = item_i.load_seconds;
        nxt.fr  = item_i.load_frames;
        nxt.sb  = item_i.load_subframes;
      end
      smpte_ts_pkg::OP_INC_FRAME:   nxt = f_frame_up(cur, cfg_i);
      smpte_ts_pkg::OP_DEC_FRAME:   nxt = f_frame_down(cur, cfg_i);
      smpte_ts_pkg::OP_INC_SUB:     nxt = f_sub_up(cur, cfg_i);
      smpte_ts_pkg::OP_DEC_SUB:     nxt = f_sub_down(cur, cfg_i);
      smpte_ts_pkg::OP_NEXT_SEC:    nxt = f_next_sec(cur, cfg_i);
      smpte_ts_pkg::OP_NEXT_MIN:    nxt = f_next_min(cur, cfg_i);
      smpte_ts_pkg::OP_NEXT_HOUR:   nxt = f_next_hour(cur, cfg_i);
      smpte_ts_pkg::OP_FLOOR_SEC:   nxt = f_floor_sec(cur, cfg_i);
      smpte_ts_pkg::OP_FLOOR_MIN:   nxt = f_floor_min(cur, cfg_i);
      smpte_ts_pkg::OP_FLOOR_HOUR:  nxt = f_floor_hour(cur);
      smpte_ts_pkg::OP_FLOOR_FRAME: nxt = f_floor_frame(cur);
      default: ;
    endcase
    nxt = f_clear(nxt);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neg_q <= 1'b0;
      hr_q  <= '0;
      mn_q  <= '0;
      sc_q  <= '0;
      fr_q  <= '0;
      sb_q  <= '0;
    end else if (adv_i) begin
      neg_q <= nxt.neg;
      hr_q  <= nxt.hr;
      mn_q  <= nxt.mn;
      sc_q  <= nxt.sc;
      fr_q  <= nxt.fr;
      sb_q  <= nxt.sb;
    end
  end

  assign res_o.wrap_level    = nxt.wrap;
  assign res_o.is_negative   = nxt.neg;
  assign res_o.hours_out     = 8'(nxt.hr);
  assign res_o.minutes_out   = nxt.mn;
  assign res_o.seconds_out   = nxt.sc;
  assign res_o.frames_out    = nxt.fr;
  assign res_o.subframes_out = nxt.sb;

endmodule

`default_nettype wire

@@ sv/smpte_timecode_stepper_top.sv @@
// Top level of the signed SMPTE timecode stepper: channels, config port, pipeline.
// A command is held in the command register and its result in the result register.
// Throughput: one command per cycle unless out_o stalls; the timecode update is one pass
//   of logic between the command register and the result register.
// Reset (rst_ni low, asynchronous): timecode is +00:00:00:00.00, both channels
//   empty, rate 30 fps, drop-frame off, 80 subframes per frame.
`default_nettype none

module smpte_timecode_stepper_top #(
  parameter int unsigned HOUR_WIDTH = smpte_ts_pkg::HOUR_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  smpte_ts_in_if.sink                         in_i,
  smpte_ts_out_if.source                      out_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [smpte_ts_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [smpte_ts_pkg::APB_DATA_W-1:0] pwdata,
  output logic [smpte_ts_pkg::APB_DATA_W-1:0] prdata,
  output logic                                pready
);

  smpte_ts_pkg::cfg_t  cfg;
  smpte_ts_pkg::item_t item_q;
  smpte_ts_pkg::res_t  res_d;
  smpte_ts_pkg::res_t  res_q;
  logic                in_valid_q;
  logic                out_valid_q;
  logic                in_fire;
  logic                adv;

  // Config registers; the user writes them only while no transaction is in flight; not enforced.
  smpte_ts_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Command register. A command moves on (adv) when the result register is
  // empty or its current contents are being taken this cycle; that same
  // edge commits the new timecode, so the next command sees it.
  assign adv       = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || adv;
  assign in_fire   = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_fire) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.op             <= in_i.op;
      item_q.load_negative  <= in_i.load_negative;
      item_q.load_hours     <= in_i.load_hours;
      item_q.load_minutes   <= in_i.load_minutes;
      item_q.load_seconds   <= in_i.load_seconds;
      item_q.load_frames    <= in_i.load_frames;
      item_q.load_subframes <= in_i.load_subframes;
    end
  end

  // Timecode state plus the per-command update logic.
  smpte_ts_core #(
    .HOUR_WIDTH (HOUR_WIDTH)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .adv_i  (adv),
    .item_i (item_q),
    .res_o  (res_d)
  );

  // Result register: holds a finished transaction while the sink stalls,
  // and the command register can still take one command behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.wrap_level    = res_q.wrap_level;
  assign out_o.is_negative   = res_q.is_negative;
  assign out_o.hours_out     = res_q.hours_out;
  assign out_o.minutes_out   = res_q.minutes_out;
  assign out_o.seconds_out   = res_q.seconds_out;
  assign out_o.frames_out    = res_q.frames_out;
  assign out_o.subframes_out = res_q.subframes_out;

endmodule

`default_nettype wire

@@ sv/smpte_ts_chk.sv @@
// Port-level checker for the timecode stepper, bound to the top level.
`default_nettype none
`include "smpte_timecode_stepper_top_macros.svh"

module smpte_ts_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [2:0] wrap_level_i,
  input logic       is_negative_i,
  input logic [7:0] hours_i,
  input logic [5:0] minutes_i,
  input logic [5:0] seconds_i,
  input logic [5:0] frames_i,
  input logic [7:0] subframes_i
);

  logic mag_nonzero;
  assign mag_nonzero = (hours_i != '0) || (minutes_i != '0) || (seconds_i != '0) ||
                       (frames_i != '0) || (subframes_i != '0);

  // A stalled result holds.
  `SMPTE_TS_ASSERT(a_out_hold, (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(wrap_level_i) && $stable(is_negative_i) && $stable(hours_i) && $stable(minutes_i) && $stable(seconds_i) && $stable(frames_i) && $stable(subframes_i)), "stalled result changed")

  // Accepted command is followed by a pending result.
  `SMPTE_TS_ASSERT(a_in_to_out, (in_valid_i && in_ready_i) |-> ##2 out_valid_i, "command produced no result")

  // Input only backs up behind a pending result.
  `SMPTE_TS_ASSERT(a_stall_cause, !in_ready_i |-> out_valid_i, "input stalled with empty output")

  // Wrap codes stop at hours; minus zero is never shown.
  `SMPTE_TS_ASSERT(a_wrap_range, out_valid_i |-> (wrap_level_i <= 3'd4), "wrap level out of range")
  `SMPTE_TS_ASSERT(a_no_neg_zero, (out_valid_i && is_negative_i) |-> mag_nonzero, "negative zero result")

endmodule

bind smpte_timecode_stepper_top smpte_ts_chk u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .wrap_level_i  (out_o.wrap_level),
  .is_negative_i (out_o.is_negative),
  .hours_i       (out_o.hours_out),
  .minutes_i     (out_o.minutes_out),
  .seconds_i     (out_o.seconds_out),
  .frames_i      (out_o.frames_out),
  .subframes_i   (out_o.subframes_out)
);

`default_nettype wire

@@ test/smpte_timecode_stepper_top_tb.sv @@
// Self-checking testbench for the SMPTE timecode stepper: directed, random and stall tests.
`timescale 1ns / 100ps

module smpte_timecode_stepper_top_tb;
  import smpte_ts_pkg::*;

  // Hours wrap at the block's default hour width.
  localparam int unsigned HOUR_MAX       = (1 << HOUR_WIDTH_DEF) - 1;
  // Longest correct stretch without a transaction is the long result hold-off
  // plus a few stall bursts; this limit is many times that.
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  // Idle clocks waited after the last owed result is back, to let the block settle.
  localparam int unsigned DRAIN_CYCLES   = 4;
  localparam int unsigned MAX_PRINTED    = 40;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  smpte_ts_in_if  cmd_if ();
  smpte_ts_out_if res_if ();

  smpte_timecode_stepper_top dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (cmd_if),
    .out_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Run control shared by the processes.
  bit          calm;           // no idling on either side once set
  int unsigned res_hold_req;   // request for a long result hold-off, in cycles
  int unsigned mismatch_count;
  int unsigned result_count;
  int unsigned idle_cycles;

  // Timecodes still owed by the block, oldest first.
  res_t expected_tc_q[$];

  // Predictor copy of the timecode and of the configuration.
  bit          tc_neg;
  int unsigned tc_hh;
  int unsigned tc_mm;
  int unsigned tc_ss;
  int unsigned tc_ff;
  int unsigned tc_sf;
  rate_e       rate_sel;
  bit          drop_sel;
  int unsigned sub_per_frame;

  // ---------------------------------------------------------------------------
  // Timecode predictor
  // ---------------------------------------------------------------------------

  task automatic timecode_reset();
    rate_sel      = rate_e'(RATE_MODE_RST);
    drop_sel      = DROP_FRAME_RST;
    sub_per_frame = SUBFRAMES_RST;
    tc_neg        = 1'b0;
    tc_hh         = 0;
    tc_mm         = 0;
    tc_ss         = 0;
    tc_ff         = 0;
    tc_sf         = 0;
  endtask

  function automatic int unsigned frame_limit();
    int unsigned t;
    case (rate_sel)
      RATE_24: t = 23;
      RATE_25: t = 24;
      RATE_30: t = 29;
      default: t = 59;
    endcase
    return t;
  endfunction

  // Drop-frame rules only apply at 30 fps.
  function automatic bit drop_rules();
    return drop_sel && (rate_sel == RATE_30);
  endfunction

  function automatic bit whole_frames_zero();
    return tc_ff == 0 && tc_ss == 0 && tc_mm == 0 && tc_hh == 0;
  endfunction

  function automatic bit tc_is_zero();
    return whole_frames_zero() && tc_sf == 0;
  endfunction

  // No minus zero: a zero magnitude is always positive.
  function automatic void clear_minus_zero();
    if (tc_is_zero()) tc_neg = 1'b0;
  endfunction

  // Magnitude up one frame. Counts above their top wrap like the top.
  function automatic wrap_e count_frame_up();
    if (tc_ff >= frame_limit()) begin
      if (drop_rules() && ((tc_mm + 1) % 10) != 0 && tc_ss == 59) tc_ff = 2;
      else tc_ff = 0;
      if (tc_ss >= 59) begin
        tc_ss = 0;
        if (tc_mm >= 59) begin
          tc_mm = 0;
          tc_hh = (tc_hh + 1) & HOUR_MAX;
          return WRAP_HOURS;
        end
        tc_mm = (tc_mm + 1) & 63;
        return WRAP_MINUTES;
      end
      tc_ss = (tc_ss + 1) & 63;
      return WRAP_SECONDS;
    end
    tc_ff = (tc_ff + 1) & 63;
    return WRAP_NONE;
  endfunction

  // Magnitude down one frame; caller guarantees a nonzero magnitude.
  function automatic wrap_e count_frame_down();
    bit carry;
    if (drop_rules() && (tc_mm % 10) != 0 && tc_ss == 0) carry = (tc_ff <= 2);
    else carry = (tc_ff == 0);
    if (carry) begin
      tc_ff = frame_limit();
      if (tc_ss == 0) begin
        tc_ss = 59;
        if (tc_mm == 0) begin
          tc_mm = 59;
          tc_hh = (tc_hh - 1) & HOUR_MAX;
          return WRAP_HOURS;
        end
        tc_mm = (tc_mm - 1) & 63;
        return WRAP_MINUTES;
      end
      tc_ss = (tc_ss - 1) & 63;
      return WRAP_SECONDS;
    end
    tc_ff = (tc_ff - 1) & 63;
    clear_minus_zero();
    return WRAP_NONE;
  endfunction

  function automatic wrap_e frame_fwd();
    wrap_e w;
    if (!tc_neg) return count_frame_up();
    // Less than one frame below zero: crosses to the positive side.
    if (whole_frames_zero() && tc_sf != 0) begin
      tc_sf  = (sub_per_frame - tc_sf) & 255;
      tc_neg = 1'b0;
      return WRAP_SECONDS;
    end
    w      = count_frame_down();
    tc_neg = !tc_is_zero();
    return w;
  endfunction

  function automatic wrap_e frame_back();
    wrap_e w;
    if (tc_neg || tc_is_zero()) begin
      w      = count_frame_up();
      tc_neg = 1'b1;
      return w;
    end
    if (whole_frames_zero() && tc_sf != 0) begin
      tc_sf  = (sub_per_frame - tc_sf) & 255;
      tc_neg = 1'b1;
      return WRAP_SECONDS;
    end
    w = count_frame_down();
    clear_minus_zero();
    return w;
  endfunction

  // Compare without wrap: 255 + 1 always carries, and so does any value at zero.
  function automatic wrap_e count_sub_up();
    if (tc_sf + 1 >= sub_per_frame) begin
      tc_sf = 0;
      void'(count_frame_up());
      return WRAP_FRAMES;
    end
    tc_sf = tc_sf + 1;
    return WRAP_NONE;
  endfunction

  function automatic wrap_e count_sub_down();
    if (tc_sf == 0) begin
      if (tc_is_zero()) begin
        tc_neg = 1'b1;
        tc_sf  = 1;
        return WRAP_FRAMES;
      end
      void'(count_frame_down());
      tc_sf = (sub_per_frame - 1) & 255;
      return WRAP_FRAMES;
    end
    tc_sf = tc_sf - 1;
    return WRAP_NONE;
  endfunction

  function automatic wrap_e sub_fwd();
    wrap_e w;
    if (!tc_neg) return count_sub_up();
    tc_neg = 1'b0;
    w      = count_sub_down();
    tc_neg = !tc_is_zero();
    return w;
  endfunction

  function automatic wrap_e sub_back();
    wrap_e w;
    if (tc_neg) begin
      tc_neg = 1'b0;
      w      = count_sub_up();
      tc_neg = 1'b1;
      return w;
    end
    return count_sub_down();
  endfunction

  function automatic void trim_subframes();
    tc_sf = 0;
    clear_minus_zero();
  endfunction

  // A dropped second starts at frame 2.
  function automatic void trim_to_second();
    trim_subframes();
    if (drop_rules() && (tc_mm % 10) != 0 && tc_ss == 0) tc_ff = 2;
    else tc_ff = 0;
    clear_minus_zero();
  endfunction

  function automatic void trim_to_minute();
    tc_ss = 0;
    trim_to_second();
  endfunction

  function automatic void trim_to_hour();
    tc_mm = 0;
    tc_ss = 0;
    tc_ff = 0;
    tc_sf = 0;
    clear_minus_zero();
  endfunction

  // Jumps go toward positive time.
  function automatic wrap_e jump_second();
    wrap_e w;
    trim_subframes();
    if (tc_neg) begin
      w = frame_fwd();
      trim_to_second();
      return w;
    end
    tc_ff = frame_limit();
    return count_frame_up();
  endfunction

  function automatic wrap_e jump_minute();
    wrap_e w;
    trim_subframes();
    if (tc_neg) begin
      w = jump_second();
      trim_to_minute();
      return w;
    end
    tc_ss = 59;
    return jump_second();
  endfunction

  function automatic wrap_e jump_hour();
    wrap_e w;
    trim_subframes();
    if (tc_neg) begin
      w = jump_minute();
      trim_to_hour();
      return w;
    end
    tc_mm = 59;
    return jump_minute();
  endfunction

  function automatic res_t predict_timecode(item_t cmd);
    wrap_e w;
    res_t  r;
    w = WRAP_NONE;
    case (cmd.op)
      OP_LOAD: begin
        tc_neg = cmd.load_negative;
        tc_hh  = cmd.load_hours & HOUR_MAX;
        tc_mm  = cmd.load_minutes;
        tc_ss  = cmd.load_seconds;
        tc_ff  = cmd.load_frames;
        tc_sf  = cmd.load_subframes;
      end
      OP_INC_FRAME:   w = frame_fwd();
      OP_DEC_FRAME:   w = frame_back();
      OP_INC_SUB:     w = sub_fwd();
      OP_DEC_SUB:     w = sub_back();
      OP_NEXT_SEC:    w = jump_second();
      OP_NEXT_MIN:    w = jump_minute();
      OP_NEXT_HOUR:   w = jump_hour();
      OP_FLOOR_SEC:   trim_to_second();
      OP_FLOOR_MIN:   trim_to_minute();
      OP_FLOOR_HOUR:  trim_to_hour();
      OP_FLOOR_FRAME: trim_subframes();
      default: ;      // unused codes leave the timecode alone
    endcase
    clear_minus_zero();
    r.wrap_level    = w;
    r.is_negative   = tc_neg;
    r.hours_out     = tc_hh[7:0];
    r.minutes_out   = tc_mm[5:0];
    r.seconds_out   = tc_ss[5:0];
    r.frames_out    = tc_ff[5:0];
    r.subframes_out = tc_sf[7:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, checking, result sink, watchdog
  // ---------------------------------------------------------------------------

  initial begin : clock_gen
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED)
      $display("mismatch: %s at result %0d: got %0d, want %0d", what, result_count, got, want);
  endtask

  // Everything is sampled at the rising edge, before any of that edge's
  // updates land. Results are checked before the command of the same edge is
  // predicted: that result can only belong to an older command.
  always @(posedge clk) begin : scoreboard
    item_t seen;
    res_t  want;
    if (rst_n) begin
      if (res_if.valid && res_if.ready) begin
        result_count++;
        if (expected_tc_q.size() == 0) begin
          report_mismatch("result with no command pending", 0, 0);
        end else begin
          want = expected_tc_q.pop_front();
          if (res_if.wrap_level !== want.wrap_level)
            report_mismatch("wrap_level", res_if.wrap_level, want.wrap_level);
          if (res_if.is_negative !== want.is_negative)
            report_mismatch("is_negative", res_if.is_negative, want.is_negative);
          if (res_if.hours_out !== want.hours_out)
            report_mismatch("hours_out", res_if.hours_out, want.hours_out);
          if (res_if.minutes_out !== want.minutes_out)
            report_mismatch("minutes_out", res_if.minutes_out, want.minutes_out);
          if (res_if.seconds_out !== want.seconds_out)
            report_mismatch("seconds_out", res_if.seconds_out, want.seconds_out);
          if (res_if.frames_out !== want.frames_out)
            report_mismatch("frames_out", res_if.frames_out, want.frames_out);
          if (res_if.subframes_out !== want.subframes_out)
            report_mismatch("subframes_out", res_if.subframes_out, want.subframes_out);
        end
      end
      if (cmd_if.valid && cmd_if.ready) begin
        seen.op             = cmd_if.op;
        seen.load_negative  = cmd_if.load_negative;
        seen.load_hours     = cmd_if.load_hours;
        seen.load_minutes   = cmd_if.load_minutes;
        seen.load_seconds   = cmd_if.load_seconds;
        seen.load_frames    = cmd_if.load_frames;
        seen.load_subframes = cmd_if.load_subframes;
        expected_tc_q.push_back(predict_timecode(seen));
      end
    end
  end

  // Result side: random stall bursts, plus a long hold-off on request that
  // this process counts down itself.
  initial begin : result_sink
    int unsigned hold_left;
    int unsigned burst_left;
    hold_left    = 0;
    burst_left   = 0;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (res_hold_req != 0) begin
        hold_left    = res_hold_req;
        res_hold_req = 0;
      end
      if (calm) burst_left = 0;
      if (hold_left != 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (burst_left != 0) begin
        burst_left--;
        res_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        burst_left = $urandom_range(0, 5);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Any transaction on either channel or the register port restarts the count.
  always @(posedge clk) begin : watchdog
    if (!rst_n || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready) || psel) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Register port
  // ---------------------------------------------------------------------------

  // Setup cycle, access cycle, then the bus goes idle.
  task automatic apb_access(input bit wr, input reg_e idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Write, mirror into the predictor, read back.
  task automatic set_register(input reg_e idx, input logic [31:0] val);
    logic [31:0] back;
    logic [31:0] mask;
    apb_access(1'b1, idx, val, back);
    case (idx)
      REG_RATE_MODE: begin
        rate_sel = rate_e'(val[1:0]);
        mask     = 32'h3;
      end
      REG_DROP_FRAME: begin
        drop_sel = val[0];
        mask     = 32'h1;
      end
      default: begin
        sub_per_frame = val[7:0];
        mask          = 32'hFF;
      end
    endcase
    apb_access(1'b0, idx, 32'd0, back);
    if (back !== (val & mask)) report_mismatch("register read-back", back, val & mask);
  endtask

  task automatic apply_setting(input rate_e rate, input bit drop, input int unsigned spf);
    set_register(REG_RATE_MODE, {30'd0, rate});
    set_register(REG_DROP_FRAME, {31'd0, drop});
    set_register(REG_SUBFRAMES, spf);
  endtask

  // ---------------------------------------------------------------------------
  // Command side
  // ---------------------------------------------------------------------------

  function automatic item_t make_load(bit neg, int unsigned hh, int unsigned mm,
                                      int unsigned ss, int unsigned ff, int unsigned sf);
    item_t it;
    it.op             = OP_LOAD;
    it.load_negative  = neg;
    it.load_hours     = hh[7:0];
    it.load_minutes   = mm[5:0];
    it.load_seconds   = ss[5:0];
    it.load_frames    = ff[5:0];
    it.load_subframes = sf[7:0];
    return it;
  endfunction

  // Load fields are don't-care for these ops; keep them toggling anyway.
  function automatic item_t make_op(logic [3:0] code);
    item_t       it;
    logic [31:0] a;
    logic [31:0] b;
    a = $urandom;
    b = $urandom;
    it.op             = code;
    it.load_negative  = a[0];
    it.load_hours     = a[8:1];
    it.load_minutes   = a[14:9];
    it.load_seconds   = a[20:15];
    it.load_frames    = a[26:21];
    it.load_subframes = b[7:0];
    return it;
  endfunction

  // Biased toward zero and the top, now and then past the top.
  function automatic int unsigned pick_field(int unsigned top, int unsigned full_max);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 3) return 0;
    if (r < 5) return top;
    if (r == 5) return $urandom_range(0, full_max);
    return $urandom_range(0, top);
  endfunction

  // Mostly stepping from a recent load, so walks run across boundaries and
  // through zero; some unused codes mixed in.
  function automatic item_t random_cmd();
    int unsigned r;
    int unsigned u;
    int unsigned sub_top;
    r       = $urandom_range(0, 99);
    sub_top = (sub_per_frame == 0) ? 255 : sub_per_frame - 1;
    if (r < 5)
      return make_load($urandom_range(0, 1), 0, 0, 0, $urandom_range(0, 2),
                       pick_field(sub_top, 255));
    if (r < 14)
      return make_load($urandom_range(0, 1), pick_field(HOUR_MAX, HOUR_MAX),
                       pick_field(59, 63), pick_field(59, 63),
                       pick_field(frame_limit(), 63), pick_field(sub_top, 255));
    if (r < 18) begin
      u = $urandom_range(12, 15);
      return make_op(u[3:0]);
    end
    if (r < 40) return make_op(OP_INC_FRAME);
    if (r < 58) return make_op(OP_DEC_FRAME);
    if (r < 70) return make_op(OP_INC_SUB);
    if (r < 82) return make_op(OP_DEC_SUB);
    u = $urandom_range(OP_NEXT_SEC, OP_FLOOR_FRAME);
    return make_op(u[3:0]);
  endfunction

  // Offer one command and hold it until the transaction; then maybe idle.
  // valid is left high when the next command follows straight away.
  task automatic send_cmd(input item_t c);
    cmd_if.valid          <= 1'b1;
    cmd_if.op             <= c.op;
    cmd_if.load_negative  <= c.load_negative;
    cmd_if.load_hours     <= c.load_hours;
    cmd_if.load_minutes   <= c.load_minutes;
    cmd_if.load_seconds   <= c.load_seconds;
    cmd_if.load_frames    <= c.load_frames;
    cmd_if.load_subframes <= c.load_subframes;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    if (!calm && $urandom_range(0, 4) == 0) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every owed result is back.
  task automatic wait_drained();
    cmd_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_tc_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset setting: 30 fps, no drop, 80 subframes.
  task automatic test_directed();
    send_cmd(make_load(1'b0, 0, 0, 0, 0, 0));
    send_cmd(make_op(OP_DEC_SUB));        // below zero by one subframe
    send_cmd(make_op(OP_INC_SUB));        // back to zero, sign cleared
    send_cmd(make_load(1'b1, 0, 0, 0, 0, 0));   // minus zero loads as plus zero
    send_cmd(make_op(OP_DEC_FRAME));
    send_cmd(make_op(OP_INC_FRAME));
    send_cmd(make_load(1'b0, 255, 59, 59, 29, 79));
    send_cmd(make_op(OP_INC_SUB));        // carries all the way, hours wrap
    send_cmd(make_load(1'b0, 1, 0, 0, 0, 0));
    send_cmd(make_op(OP_DEC_SUB));        // subframe borrow through hours
    send_cmd(make_load(1'b1, 0, 0, 0, 0, 5));
    send_cmd(make_op(OP_INC_FRAME));      // crosses zero by subframes
    send_cmd(make_load(1'b0, 0, 0, 0, 0, 5));
    send_cmd(make_op(OP_DEC_FRAME));
    send_cmd(make_load(1'b0, 255, 63, 63, 63, 255));   // hours at their top, every other count above its top
    send_cmd(make_op(OP_INC_FRAME));
    send_cmd(make_load(1'b1, 1, 2, 3, 4, 5));
    send_cmd(make_op(OP_NEXT_HOUR));
    send_cmd(make_op(OP_NEXT_SEC));
    send_cmd(make_load(1'b0, 1, 2, 3, 4, 5));
    send_cmd(make_op(OP_NEXT_SEC));
    send_cmd(make_op(OP_NEXT_MIN));
    send_cmd(make_op(OP_NEXT_HOUR));
    send_cmd(make_load(1'b0, 12, 34, 56, 17, 40));
    send_cmd(make_op(OP_FLOOR_FRAME));
    send_cmd(make_op(OP_FLOOR_SEC));
    send_cmd(make_op(OP_FLOOR_MIN));
    send_cmd(make_op(OP_FLOOR_HOUR));
    send_cmd(make_op(4'd15));             // unused code
  endtask

  // 30 fps drop-frame: frames 0 and 1 skipped except every tenth minute.
  task automatic test_drop_frame();
    wait_drained();
    apply_setting(RATE_30, 1'b1, 80);
    send_cmd(make_load(1'b0, 0, 0, 59, 29, 0));
    send_cmd(make_op(OP_INC_FRAME));      // lands on frame 2
    send_cmd(make_op(OP_DEC_FRAME));      // frame 2 borrows
    send_cmd(make_load(1'b0, 0, 9, 59, 29, 0));
    send_cmd(make_op(OP_INC_FRAME));      // tenth minute keeps frame 0
    send_cmd(make_load(1'b0, 0, 1, 0, 15, 7));
    send_cmd(make_op(OP_FLOOR_SEC));
    send_cmd(make_load(1'b1, 0, 3, 27, 10, 0));
    send_cmd(make_op(OP_FLOOR_MIN));
    repeat (300) send_cmd(random_cmd());
  endtask

  // Other rates and subframe counts, the extremes among them. Drop is set at
  // 25 fps where it must have no effect; zero subframes makes every subframe step up carry.
  task automatic test_rate_sweep();
    wait_drained();
    apply_setting(RATE_24, 1'b0, 1);
    repeat (200) send_cmd(random_cmd());
    wait_drained();
    apply_setting(RATE_25, 1'b1, 255);
    repeat (200) send_cmd(random_cmd());
    wait_drained();
    apply_setting(RATE_60, 1'b0, 0);
    repeat (200) send_cmd(random_cmd());
    wait_drained();
    apply_setting(RATE_30, 1'b1, 3);
    repeat (200) send_cmd(random_cmd());
  endtask

  // Result side holds off long enough for the block to fill and stall the
  // command side; then the sender waits for a full drain before going on.
  task automatic test_backpressure();
    wait_drained();
    apply_setting(RATE_60, 1'b1, 80);
    res_hold_req = 150;
    repeat (60) send_cmd(random_cmd());
    wait_drained();
    repeat (40) send_cmd(random_cmd());
  endtask

  // Back to back on both sides.
  task automatic test_steady_stream();
    wait_drained();
    apply_setting(RATE_30, 1'b0, 80);
    calm = 1'b1;
    repeat (300) send_cmd(random_cmd());
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin : main
    rst_n                 = 1'b0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    cmd_if.valid          = 1'b0;
    cmd_if.op             = OP_LOAD;
    cmd_if.load_negative  = 1'b0;
    cmd_if.load_hours     = '0;
    cmd_if.load_minutes   = '0;
    cmd_if.load_seconds   = '0;
    cmd_if.load_frames    = '0;
    cmd_if.load_subframes = '0;
    timecode_reset();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_drop_frame();
    test_rate_sweep();
    test_backpressure();
    test_steady_stream();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/smpte_ts_pkg.sv
sv/smpte_ts_in_if.sv
sv/smpte_ts_out_if.sv
sv/smpte_ts_cfg.sv
sv/smpte_ts_core.sv
sv/smpte_timecode_stepper_top.sv
sv/smpte_ts_chk.sv
test/smpte_timecode_stepper_top_tb.sv
